[rtl/core/ghash_pkg.sv]
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types and constants for the GHASH tag accumulator.
// ----------------------------------------------------------------------------
package ghash_pkg;

  // Block geometry
  localparam int unsigned BLOCK_BITS  = 128;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned WORD_BYTES  = 8;

  // Multiplier slice: key bits consumed per cycle and cycles per product
  localparam int unsigned MUL_BITS   = 16;
  localparam int unsigned MUL_CYCLES = BLOCK_BITS / MUL_BITS;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_CYCLES);

  // Reduction constant for x^128 + x^7 + x^2 + x + 1 in reflected bit order
  localparam logic [WORD_BITS-1:0] GF_REDUCE = 64'hE100_0000_0000_0000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HASH_KEY_HIGH = 2'd0,
    CFG_HASH_KEY_LOW  = 2'd1,
    CFG_TAG_MASK_HIGH = 2'd2,
    CFG_TAG_MASK_LOW  = 2'd3
  } cfg_index_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_MUL_DATA = 4'b0010,
    ST_MUL_LEN  = 4'b0100,
    ST_EMIT     = 4'b1000
  } state_e;

endpackage

[rtl/core/ghash_tag_accumulator.sv]
// ----------------------------------------------------------------------------
// ghash_tag_accumulator
// GCM GHASH over ciphertext blocks with length block and J0 tag mask.
// ----------------------------------------------------------------------------
// Each request carries one ciphertext block of up to 16 bytes; the block is
// zero-padded, folded into the 128-bit accumulator and multiplied by H in
// GF(2^128). The multiplier handles 16 key bits per cycle, and the input
// stays stalled while a data block is multiplied. A request marked last then
// absorbs the length block and places the tag in the output register once
// that register is free; an empty final block absorbs only the length block.
// While an earlier tag is still stalled there, the sequencer waits in its
// emit state until it is taken. An empty non-final block is dropped
// in the cycle it is taken. The tag waits in its output register while the
// next message starts. H and the mask are to be written through the configuration
// port only while the block is idle; the block itself does not enforce this.
module ghash_tag_accumulator #(
  parameter int unsigned LENGTH_BITS = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input blocks
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_i,
  // tag output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] tag_high_o,
  output logic [63:0] tag_low_o
);
  import ghash_pkg::*;

  // 16 shift-and-add steps of the bit-serial GCM multiply
  function automatic logic [2*BLOCK_BITS-1:0] gf_slice(
    input logic [BLOCK_BITS-1:0] z_in,
    input logic [BLOCK_BITS-1:0] v_in,
    input logic [MUL_BITS-1:0]   k_in
  );
    logic [BLOCK_BITS-1:0] z;
    logic [BLOCK_BITS-1:0] v;
    logic                  carry;
    z = z_in;
    v = v_in;
    for (int j = 0; j < MUL_BITS; j++) begin
      if (k_in[MUL_BITS-1-j]) begin
        z = z ^ v;
      end
      carry = v[0];
      v     = v >> 1;
      if (carry) begin
        v[BLOCK_BITS-1 -: WORD_BITS] = v[BLOCK_BITS-1 -: WORD_BITS] ^ GF_REDUCE;
      end
    end
    return {z, v};
  endfunction

  // Keep the first n bytes of a word, byte 0 in the top bits
  function automatic logic [WORD_BITS-1:0] byte_mask(input logic [4:0] n);
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      if (5'(b) < n) begin
        m[WORD_BITS-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Registers
  state_e                  state_q, state_d;
  logic [WORD_BITS-1:0]    key_high_q, key_low_q, mask_high_q, mask_low_q;
  logic [BLOCK_BITS-1:0]   acc_q, acc_d;
  logic [LENGTH_BITS-1:0]  total_q, total_d;
  logic                    last_q, last_d;
  logic [MUL_CNT_W-1:0]    cnt_q, cnt_d;
  logic [BLOCK_BITS-1:0]   z_q, z_d, v_q, v_d, k_q, k_d;
  logic                    out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0]    tag_high_q, tag_high_d, tag_low_q, tag_low_d;

  // Combinational helpers
  logic                    in_req;
  logic [4:0]              n_clamped;
  logic [4:0]              n_low;
  logic [BLOCK_BITS-1:0]   block_masked;
  logic [2*BLOCK_BITS-1:0] slice_out;
  logic [BLOCK_BITS-1:0]   z_next;
  logic [WORD_BITS-1:0]    len_word;
  logic                    mul_done;
  logic                    out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_req     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Clamp the count and build the padded block
  assign n_clamped    = (byte_count_i > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : byte_count_i;
  assign n_low        = (n_clamped > 5'(WORD_BYTES)) ? n_clamped - 5'(WORD_BYTES) : 5'd0;
  assign block_masked = {block_high_i & byte_mask(n_clamped), block_low_i & byte_mask(n_low)};

  // Multiplier slice and length block
  assign slice_out = gf_slice(z_q, v_q, k_q[BLOCK_BITS-1 -: MUL_BITS]);
  assign z_next    = slice_out[2*BLOCK_BITS-1 -: BLOCK_BITS];
  assign len_word  = WORD_BITS'({total_q, 3'b000});
  assign mul_done  = (cnt_q == MUL_CNT_W'(MUL_CYCLES - 1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    total_d     = total_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    z_d         = z_q;
    v_d         = v_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    tag_high_d  = tag_high_q;
    tag_low_d   = tag_low_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          last_d = last_i;
          cnt_d  = '0;
          z_d    = '0;
          k_d    = {key_high_q, key_low_q};
          if (n_clamped != 5'd0) begin
            v_d     = acc_q ^ block_masked;
            total_d = total_q + LENGTH_BITS'(n_clamped);
            state_d = ST_MUL_DATA;
          end else if (last_i) begin
            v_d     = acc_q ^ {{WORD_BITS{1'b0}}, len_word};
            state_d = ST_MUL_LEN;
          end
        end
      end
      ST_MUL_DATA: begin
        z_d   = z_next;
        v_d   = slice_out[BLOCK_BITS-1:0];
        k_d   = k_q << MUL_BITS;
        cnt_d = cnt_q + 1'b1;
        if (mul_done) begin
          if (last_q) begin
            cnt_d   = '0;
            z_d     = '0;
            k_d     = {key_high_q, key_low_q};
            v_d     = z_next ^ {{WORD_BITS{1'b0}}, len_word};
            state_d = ST_MUL_LEN;
          end else begin
            acc_d   = z_next;
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL_LEN: begin
        z_d   = z_next;
        v_d   = slice_out[BLOCK_BITS-1:0];
        k_d   = k_q << MUL_BITS;
        cnt_d = cnt_q + 1'b1;
        if (mul_done) begin
          acc_d   = z_next;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the output register, then hand over and clear
        if (out_free) begin
          out_valid_d = 1'b1;
          tag_high_d  = acc_q[BLOCK_BITS-1 -: WORD_BITS] ^ mask_high_q;
          tag_low_d   = acc_q[WORD_BITS-1:0] ^ mask_low_q;
          acc_d       = '0;
          total_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      total_q     <= '0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      total_q     <= total_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Multiplier operands and tag payload
  always_ff @(posedge clk_i) begin
    z_q        <= z_d;
    v_q        <= v_d;
    k_q        <= k_d;
    tag_high_q <= tag_high_d;
    tag_low_q  <= tag_low_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q  <= '0;
      key_low_q   <= '0;
      mask_high_q <= '0;
      mask_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_HASH_KEY_HIGH: key_high_q  <= cfg_data_i;
        CFG_HASH_KEY_LOW:  key_low_q   <= cfg_data_i;
        CFG_TAG_MASK_HIGH: mask_high_q <= cfg_data_i;
        CFG_TAG_MASK_LOW:  mask_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_high_o  = tag_high_q;
  assign tag_low_o   = tag_low_q;

endmodule

[rtl/core/ghash_checker.sv]
// ----------------------------------------------------------------------------
// ghash_checker
// Port-level assertions for the GHASH tag accumulator, bound to the top.
// ----------------------------------------------------------------------------
module ghash_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [4:0]  byte_count_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] tag_high_o,
  input logic [63:0] tag_low_o
);
  import ghash_pkg::*;

  // A stalled tag stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tag_high_o) && $stable(tag_low_o))
    else $error("tag changed or vanished while stalled");

  // Any request with data or last starts a multiply and blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (byte_count_i != 5'd0 || last_i) |=> in_stall_o)
    else $error("working request did not stall the input");

  // The input is still blocked when a multiply reaches its last slice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> ##(MUL_CYCLES - 1) in_stall_o)
    else $error("input released before the multiply finished");

  // A fresh tag only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("tag appeared without a preceding busy period");

endmodule

bind ghash_tag_accumulator ghash_checker u_ghash_checker (.*);
